@@ design/assert_macros.svh @@
// Assertion helpers for the RTL, included by wtlds_step.
// All checks run on the rising edge of clk and are off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold on every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold on the clock edge after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/wtlds_pkg.sv @@
// ----------------------------------------------------------------------------
// wtlds_pkg
// Types and constants for the wireless transmitter load-detect sequencer.
// ----------------------------------------------------------------------------
package wtlds_pkg;

  // Phase lengths in ticks
  localparam int LOADED_TICKS = 200;
  localparam int OFF_TICKS    = 100;

  // Phase step counter layout
  localparam int STEP_W = 9;
  localparam logic [STEP_W-1:0] STEP_IDLE         = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_SETTLE_LAST  = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_PROBE        = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_LOADED_FIRST = STEP_W'(10);
  localparam logic [STEP_W-1:0] STEP_OFF_FIRST    = STEP_W'(10 + LOADED_TICKS);
  localparam logic [STEP_W-1:0] STEP_OFF_END      = STEP_W'(10 + LOADED_TICKS + OFF_TICKS);

  // floor(x*11/10) for 12-bit x as (x * MUL_11_10) >> SHIFT_11_10
  localparam logic [19:0] MUL_11_10   = 20'd576719;
  localparam int          SHIFT_11_10 = 19;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TX_MODE       = 3'd0,
    REG_NO_LOAD_THR   = 3'd1,
    REG_CAL_START_THR = 3'd2,
    REG_CAL_DURATION  = 3'd3,
    REG_TEMP_ON       = 3'd4,
    REG_TEMP_OFF      = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_AUTO    = 2'd1,
    MODE_CONT    = 2'd2,
    MODE_CONT_LP = 2'd3
  } tx_mode_t;

  // Reset values of the registers
  localparam logic [11:0]        RST_NO_LOAD_THR   = 12'd931;
  localparam logic [11:0]        RST_CAL_START_THR = 12'd186;
  localparam logic [15:0]        RST_CAL_DURATION  = 16'd1800;
  localparam logic signed [7:0]  RST_TEMP_ON       = 8'sd62;
  localparam logic signed [7:0]  RST_TEMP_OFF      = 8'sd58;

  // Register file contents seen by the step logic
  typedef struct packed {
    tx_mode_t           tx_mode;
    logic [11:0]        cal_start_threshold;
    logic [15:0]        cal_duration_ticks;
    logic signed [7:0]  temp_on_limit;
    logic signed [7:0]  temp_off_limit;
    logic               thr_load;
    logic [11:0]        thr_value;
  } cfg_t;

  // One tick in
  typedef struct packed {
    logic [11:0]       avg_current;
    logic signed [7:0] die_temp;
    logic              start_calibration;
  } item_t;

  // One result out
  typedef struct packed {
    logic        tx_enable;
    logic [11:0] threshold_now;
    logic        thermal_blocked;
    logic        calibrating;
    logic        save_request;
  } result_t;

endpackage

@@ design/wtlds_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// wtlds_cfg_regs
// Configuration register file, written over its own valid/ready channel.
// ----------------------------------------------------------------------------
module wtlds_cfg_regs import wtlds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  tx_mode_t          tx_mode;
  logic [11:0]       cal_start_threshold;
  logic [15:0]       cal_duration_ticks;
  logic signed [7:0] temp_on_limit;
  logic signed [7:0] temp_off_limit;
  logic              thr_load;
  logic [11:0]       thr_value;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_mode             <= MODE_AUTO;
      cal_start_threshold <= RST_CAL_START_THR;
      cal_duration_ticks  <= RST_CAL_DURATION;
      temp_on_limit       <= RST_TEMP_ON;
      temp_off_limit      <= RST_TEMP_OFF;
    end else begin
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_TX_MODE:       tx_mode <= tx_mode_t'(cfg_data[1:0]);
          REG_CAL_START_THR: cal_start_threshold <= cfg_data[11:0];
          REG_CAL_DURATION:  cal_duration_ticks <= cfg_data;
          REG_TEMP_ON:       temp_on_limit <= $signed(cfg_data[7:0]);
          REG_TEMP_OFF:      temp_off_limit <= $signed(cfg_data[7:0]);
          default: ;
        endcase
      end
    end
  end

  // Threshold write goes straight into the working threshold at the same edge
  assign thr_load  = cfg_valid && (cfg_index == REG_NO_LOAD_THR);
  assign thr_value = cfg_data[11:0];

  assign cfg = '{tx_mode:             tx_mode,
                 cal_start_threshold: cal_start_threshold,
                 cal_duration_ticks:  cal_duration_ticks,
                 temp_on_limit:       temp_on_limit,
                 temp_off_limit:      temp_off_limit,
                 thr_load:            thr_load,
                 thr_value:           thr_value};

endmodule

@@ design/wtlds_step.sv @@
// ----------------------------------------------------------------------------
// wtlds_step
// Sequencer state and the per-tick update: phase step, calibration, thermal.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wtlds_step import wtlds_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    advance,
  input  item_t   item,
  output result_t result
);

  logic [STEP_W-1:0] phase_step, phase_step_next;
  logic              tx_on, tx_on_next;
  logic [11:0]       working_threshold, working_threshold_next;
  logic              cal_active, cal_active_next;
  logic [15:0]       cal_ticks_left, cal_ticks_left_next;
  logic              thermal_latch, thermal_latch_next;
  logic              save_next;

  // floor(current*11/10), one constant multiply
  logic [31:0] lower_prod;
  logic [12:0] lower_val;
  logic        lower_hit;
  logic        below_thr;
  logic [11:0] thr_start;
  logic        cal_start;
  logic [15:0] ticks_start;

  assign lower_prod = 32'(item.avg_current) * 32'(MUL_11_10);
  assign lower_val  = lower_prod[SHIFT_11_10 +: 13];

  // Calibration start is applied before the step
  assign thr_start   = item.start_calibration ? cfg.cal_start_threshold : working_threshold;
  assign cal_start   = item.start_calibration | cal_active;
  assign ticks_start = item.start_calibration ? cfg.cal_duration_ticks : cal_ticks_left;
  assign below_thr   = item.avg_current < thr_start;
  assign lower_hit   = lower_val < {1'b0, thr_start};

  // Next state for one tick
  always_comb begin
    phase_step_next        = phase_step;
    tx_on_next             = tx_on;
    working_threshold_next = thr_start;
    cal_active_next        = cal_start;
    cal_ticks_left_next    = ticks_start;
    thermal_latch_next     = thermal_latch;
    save_next              = 1'b0;

    // phase step
    if (cfg.tx_mode == MODE_OFF) begin
      tx_on_next      = 1'b0;
      phase_step_next = STEP_IDLE;
    end else if (phase_step == STEP_IDLE) begin
      tx_on_next      = ~thermal_latch;
      phase_step_next = STEP_W'(1);
    end else if (phase_step <= STEP_SETTLE_LAST) begin
      phase_step_next = phase_step + STEP_W'(1);
    end else if (phase_step == STEP_PROBE) begin
      if (cfg.tx_mode == MODE_AUTO) begin
        phase_step_next = below_thr ? STEP_OFF_FIRST : STEP_LOADED_FIRST;
      end else begin
        phase_step_next = STEP_SETTLE_LAST;
      end
    end else if (phase_step >= STEP_OFF_FIRST && phase_step < STEP_OFF_END) begin
      phase_step_next = phase_step + STEP_W'(1);
      if (tx_on && cal_start && lower_hit) begin
        working_threshold_next = lower_val[11:0];
      end
      tx_on_next = 1'b0;
    end else if (phase_step >= STEP_LOADED_FIRST && phase_step < STEP_OFF_FIRST) begin
      phase_step_next = phase_step + STEP_W'(1);
      if (below_thr) begin
        if (cal_start && lower_hit) begin
          working_threshold_next = lower_val[11:0];
        end
        phase_step_next = STEP_PROBE;
      end
    end else begin
      phase_step_next = STEP_IDLE;
    end

    // calibration countdown
    if (cal_start) begin
      if (ticks_start != 16'd0) begin
        cal_ticks_left_next = ticks_start - 16'd1;
      end
      if (ticks_start <= 16'd1) begin
        cal_active_next = 1'b0;
        save_next       = 1'b1;
      end
    end

    // thermal latch with hysteresis; set test first
    if ($signed(item.die_temp) > $signed(cfg.temp_on_limit)) begin
      tx_on_next         = 1'b0;
      thermal_latch_next = 1'b1;
    end
    if ($signed(item.die_temp) < $signed(cfg.temp_off_limit)) begin
      thermal_latch_next = 1'b0;
    end
  end

  assign result = '{tx_enable:       tx_on_next,
                    threshold_now:   working_threshold_next,
                    thermal_blocked: thermal_latch_next,
                    calibrating:     cal_active_next,
                    save_request:    save_next};

  // State registers, stepped once per transfer out of the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step        <= STEP_IDLE;
      tx_on             <= 1'b0;
      working_threshold <= RST_NO_LOAD_THR;
      cal_active        <= 1'b0;
      cal_ticks_left    <= 16'd0;
      thermal_latch     <= 1'b0;
    end else if (cfg.thr_load) begin
      working_threshold <= cfg.thr_value;
    end else if (advance) begin
      phase_step        <= phase_step_next;
      tx_on             <= tx_on_next;
      working_threshold <= working_threshold_next;
      cal_active        <= cal_active_next;
      cal_ticks_left    <= cal_ticks_left_next;
      thermal_latch     <= thermal_latch_next;
    end
  end

  `ASSERT_ALWAYS(a_step_range, phase_step <= STEP_OFF_END, "phase step out of range")
  `ASSERT_ALWAYS(a_thermal_off, !(thermal_latch && tx_on), "enable high while thermal latch set")
  `ASSERT_NEXT(a_save_ends_cal, advance && save_next, !cal_active, "save without end of calibration")

endmodule

@@ design/wireless_tx_load_detect_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// wireless_tx_load_detect_sequencer_unit
// Load-detect sequencer for a wireless power transmitter, one step per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one 100 ms tick: averaged
//   current, die temperature and a calibration start flag. Output channel
//   (out_valid/out_ready) returns one result per tick: enable, working
//   threshold, thermal block, calibration flag and a one-tick save request.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   registers; cfg_ready is always high. Write only while the block is idle.
// Timing:
//   A tick lands in the input register, is stepped through the state logic
//   and its result is registered. One tick per cycle sustained while the
//   output is not stalled; the state registers update once per tick.
// Reset:
//   rst clears the sequencer to step 0 with the transmitter off and loads
//   the register defaults. No pending transfers survive reset.
// Stall:
//   A held output result stalls the input register, and in_ready drops once
//   it is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module wireless_tx_load_detect_sequencer_unit import wtlds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // tick input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [11:0]           avg_current,
  input  logic signed [7:0]     die_temp,
  input  logic                  start_calibration,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  tx_enable,
  output logic [11:0]           threshold_now,
  output logic                  thermal_blocked,
  output logic                  calibrating,
  output logic                  save_request
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_q_valid;
  logic    advance;
  result_t step_res;
  result_t out_q;

  assign cfg_ready = 1'b1;

  wtlds_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input stage moves on when the result register is free or draining
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= '{avg_current: avg_current, die_temp: die_temp,
                start_calibration: start_calibration};
    end
  end

  wtlds_step u_step (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (in_q),
    .result  (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign tx_enable       = out_q.tx_enable;
  assign threshold_now   = out_q.threshold_now;
  assign thermal_blocked = out_q.thermal_blocked;
  assign calibrating     = out_q.calibrating;
  assign save_request    = out_q.save_request;

endmodule

@@ bench/load_detect_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_detect_checker
// Passive scoreboard for the load-detect sequencer. It copies every register
// write into its own register state and predicts the result of each accepted
// tick. It then compares each result transfer, field by field, with the
// oldest prediction.
// ----------------------------------------------------------------------------
module load_detect_checker import wtlds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration channel
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // tick channel
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [11:0]           avg_current,
  input  logic signed [7:0]     die_temp,
  input  logic                  start_calibration,
  // result channel
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  tx_enable,
  input  logic [11:0]           threshold_now,
  input  logic                  thermal_blocked,
  input  logic                  calibrating,
  input  logic                  save_request,
  // status to the bench top
  output int                    mismatches,
  output int                    outstanding
);

  localparam int REPORT_LIMIT = 10;

  // Register copies
  tx_mode_t          mode;
  logic [11:0]       cal_start_thr;
  logic [15:0]       cal_length;
  logic signed [7:0] hot_limit;
  logic signed [7:0] cool_limit;

  // Sequencer state copies
  logic [STEP_W-1:0] step;
  logic              tx_on;
  logic [11:0]       thr;
  logic              cal_on;
  logic [15:0]       cal_left;
  logic              hot;

  result_t expected_results[$];
  int      miss_count;

  // Enable request, vetoed while the thermal latch is set
  function automatic void request_enable(input logic want);
    tx_on = hot ? 1'b0 : want;
  endfunction

  // Calibration trim: threshold drops to floor(current * 1.1) when lower
  function automatic void trim_threshold(input logic [11:0] cur);
    int unsigned scaled;
    scaled = (32'(cur) * 11) / 10;
    if (scaled < 32'(thr))
      thr = scaled[11:0];
  endfunction

  // One tick: calibration start, phase step, countdown, thermal latch
  function automatic result_t advance_tick(input logic [11:0] cur,
                                           input logic signed [7:0] temp,
                                           input logic cal_go);
    result_t r;
    logic    save;
    save = 1'b0;

    if (cal_go) begin
      cal_left = cal_length;
      thr      = cal_start_thr;
      cal_on   = 1'b1;
    end

    if (mode == MODE_OFF) begin
      request_enable(1'b0);
      step = STEP_IDLE;
    end else if (step == STEP_IDLE) begin
      request_enable(1'b1);
      step = STEP_IDLE + 1'b1;
    end else if (step <= STEP_SETTLE_LAST) begin
      step = step + 1'b1;
    end else if (step == STEP_PROBE) begin
      if (mode == MODE_AUTO)
        step = (cur < thr) ? STEP_OFF_FIRST : STEP_LOADED_FIRST;
      else
        step = STEP_SETTLE_LAST;
    end else if (step >= STEP_OFF_FIRST && step < STEP_OFF_END) begin
      // no-load hold-off: the enable drops on every tick
      step = step + 1'b1;
      if (tx_on && cal_on)
        trim_threshold(cur);
      request_enable(1'b0);
    end else if (step >= STEP_LOADED_FIRST && step < STEP_OFF_FIRST) begin
      // loaded: re-probe as soon as the current falls below threshold
      step = step + 1'b1;
      if (cur < thr) begin
        if (cal_on)
          trim_threshold(cur);
        step = STEP_PROBE;
      end
    end else begin
      step = STEP_IDLE;
    end

    if (cal_on) begin
      if (cal_left != 16'd0)
        cal_left = cal_left - 16'd1;
      if (cal_left == 16'd0) begin
        cal_on = 1'b0;
        save   = 1'b1;
      end
    end

    // set test first, then clear test on the same reading
    if (temp > hot_limit) begin
      tx_on = 1'b0;
      hot   = 1'b1;
    end
    if (temp < cool_limit && hot)
      hot = 1'b0;

    r.tx_enable       = tx_on;
    r.threshold_now   = thr;
    r.thermal_blocked = hot;
    r.calibrating     = cal_on;
    r.save_request    = save;
    return r;
  endfunction

  // Channel monitor: register writes, result compare, tick prediction
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      mode          = MODE_AUTO;
      cal_start_thr = RST_CAL_START_THR;
      cal_length    = RST_CAL_DURATION;
      hot_limit     = RST_TEMP_ON;
      cool_limit    = RST_TEMP_OFF;
      step          = STEP_IDLE;
      tx_on         = 1'b0;
      thr           = RST_NO_LOAD_THR;
      cal_on        = 1'b0;
      cal_left      = 16'd0;
      hot           = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TX_MODE:       mode = tx_mode_t'(cfg_data[1:0]);
          REG_NO_LOAD_THR:   thr = cfg_data[11:0];
          REG_CAL_START_THR: cal_start_thr = cfg_data[11:0];
          REG_CAL_DURATION:  cal_length = cfg_data;
          REG_TEMP_ON:       hot_limit = signed'(cfg_data[7:0]);
          REG_TEMP_OFF:      cool_limit = signed'(cfg_data[7:0]);
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (miss_count < REPORT_LIMIT)
            $display("%0t: result transfer with no tick pending", $time);
          miss_count++;
        end else begin
          want = expected_results.pop_front();
          if (tx_enable !== want.tx_enable || threshold_now !== want.threshold_now ||
              thermal_blocked !== want.thermal_blocked ||
              calibrating !== want.calibrating || save_request !== want.save_request) begin
            if (miss_count < REPORT_LIMIT) begin
              $display("%0t: mismatch, expected en %0b thr %0d blk %0b cal %0b save %0b",
                       $time, want.tx_enable, want.threshold_now, want.thermal_blocked,
                       want.calibrating, want.save_request);
              $display("%0t:           actual en %0b thr %0d blk %0b cal %0b save %0b",
                       $time, tx_enable, threshold_now, thermal_blocked,
                       calibrating, save_request);
            end
            miss_count++;
          end
        end
      end

      if (in_valid && in_ready)
        expected_results.push_back(advance_tick(avg_current, die_temp, start_calibration));
    end
    mismatches  <= miss_count;
    outstanding <= expected_results.size();
  end

endmodule

@@ bench/tb_wireless_tx_load_detect_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wireless_tx_load_detect_sequencer_unit
// Stimulus and verdict for the load-detect sequencer. A directed opening runs
// the field extremes, the probe decisions, calibration start and restart,
// zero and full calibration lengths, swapped thermal limits and every mode.
// Random phases follow, each under new register settings and with its own load
// profile. Random idle bursts fall on both channels. The checker beside the
// block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_wireless_tx_load_detect_sequencer_unit import wtlds_pkg::*;;

  localparam int TOTAL_TICKS    = 1250;
  localparam int QUIET_TAIL     = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  // index past the register map, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum logic [1:0] {
    LOAD_MIXED,
    LOAD_HEAVY,
    LOAD_NONE,
    LOAD_NEAR
  } load_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [11:0]           avg_current = '0;
  logic signed [7:0]     die_temp = '0;
  logic                  start_calibration = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  tx_enable;
  logic [11:0]           threshold_now;
  logic                  thermal_blocked;
  logic                  calibrating;
  logic                  save_request;

  int          mismatches;
  int          outstanding;
  bit          tx_gaps;
  bit          rx_stalls;
  int          stall_left;
  int          idle_cycles;
  int          results_seen;
  int          ticks_sent;
  int          cal_starts;
  int          settings_used = 1;
  logic [11:0] probe_level = RST_NO_LOAD_THR;

  wireless_tx_load_detect_sequencer_unit u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .avg_current       (avg_current),
    .die_temp          (die_temp),
    .start_calibration (start_calibration),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .tx_enable         (tx_enable),
    .threshold_now     (threshold_now),
    .thermal_blocked   (thermal_blocked),
    .calibrating       (calibrating),
    .save_request      (save_request)
  );

  load_detect_checker u_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .avg_current       (avg_current),
    .die_temp          (die_temp),
    .start_calibration (start_calibration),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .tx_enable         (tx_enable),
    .threshold_now     (threshold_now),
    .thermal_blocked   (thermal_blocked),
    .calibrating       (calibrating),
    .save_request      (save_request),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result sink: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (out_valid && out_ready)
      results_seen <= results_seen + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // One tick transfer, with an optional idle burst ahead of it
  task automatic send_tick(input logic [11:0] cur, input logic signed [7:0] temp,
                           input logic cal_go);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    avg_current       <= cur;
    die_temp          <= temp;
    start_calibration <= cal_go;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
    if (cal_go)
      cal_starts++;
  endtask

  // Hold the sender until every predicted result has been transferred
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Full register set, written once the block is idle; unused upper bits
  // carry noise
  task automatic apply_settings(input tx_mode_t mode, input logic [11:0] thr,
                                input logic [11:0] cal_thr, input logic [15:0] cal_len,
                                input logic signed [7:0] hot_c,
                                input logic signed [7:0] cool_c);
    wait_for_results();
    write_reg(REG_UNMAPPED, 16'($urandom));
    write_reg(REG_TX_MODE, {14'($urandom), mode});
    write_reg(REG_NO_LOAD_THR, {4'($urandom), thr});
    write_reg(REG_CAL_START_THR, {4'($urandom), cal_thr});
    write_reg(REG_CAL_DURATION, cal_len);
    write_reg(REG_TEMP_ON, {8'($urandom), hot_c});
    write_reg(REG_TEMP_OFF, {8'($urandom), cool_c});
    cfg_valid   <= 1'b0;
    probe_level  = thr;
    settings_used++;
  endtask

  function automatic logic [11:0] pick_current(input load_kind_t load);
    int near;
    case (load)
      LOAD_HEAVY:
        return ($urandom_range(0, 299) == 0) ? 12'($urandom) : 12'($urandom_range(3800, 4095));
      LOAD_NONE:
        return 12'($urandom_range(0, 300));
      LOAD_NEAR: begin
        near = int'(probe_level) + int'($urandom_range(0, 32)) - 16;
        if (near < 0)
          near = 0;
        if (near > 4095)
          near = 4095;
        return 12'(near);
      end
      default:
        return 12'($urandom);
    endcase
  endfunction

  // Mostly working range, rare full-range and hot; all full range in hot phases
  function automatic logic signed [7:0] pick_temp(input bit hot_phase);
    int roll;
    roll = $urandom_range(0, 39);
    if (hot_phase || roll == 0)
      return 8'($urandom);
    if (roll == 1)
      return 8'($urandom_range(63, 127));
    return 8'(int'($urandom_range(0, 90)) - 40);
  endfunction

  initial begin : stimulus
    tx_mode_t          mode;
    load_kind_t        load;
    logic [11:0]       thr;
    logic [11:0]       cal_thr;
    logic [15:0]       cal_len;
    logic signed [7:0] hot_c;
    logic signed [7:0] cool_c;
    int                len;
    int                pick;
    bit                cal_phase;
    bit                hot_phase;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, auto mode, power up through probe
    send_tick(12'd0, 8'sd25, 1'b0);
    send_tick(12'hFFF, -8'sd128, 1'b0);
    send_tick(12'hAAA, 8'sd127, 1'b0);       // thermal latch sets
    send_tick(12'h555, 8'sd59, 1'b0);        // inside hysteresis band
    send_tick(12'd931, 8'sd57, 1'b0);        // probe at threshold: loaded
    send_tick(12'd930, 8'sd20, 1'b0);        // just below: re-probe
    send_tick(12'd500, 8'sd20, 1'b1);        // calibration start, probe loaded
    send_tick(12'd150, 8'sd125, 1'b0);       // trim while loaded, hot
    send_tick(12'd0, -8'sd1, 1'b0);          // probe: no load
    send_tick(12'd4095, -8'sd40, 1'b1);      // restart while calibrating
    wait_for_results();

    // Continuous, zero calibration length, limits swapped at the extremes
    apply_settings(MODE_CONT, 12'hFFF, 12'hFFF, 16'd0, -8'sd128, 8'sd127);
    send_tick(12'hFFF, -8'sd128, 1'b0);
    send_tick(12'd0, 8'sd127, 1'b1);
    send_tick(12'd100, 8'sd0, 1'b0);
    send_tick(12'd100, 8'sd0, 1'b0);
    send_tick(12'd100, 8'sd0, 1'b0);

    apply_settings(MODE_OFF, 12'd0, 12'd0, 16'd1, 8'sd62, 8'sd58);
    send_tick(12'd2048, 8'sd30, 1'b1);
    send_tick(12'd1024, 8'sd30, 1'b0);

    apply_settings(MODE_CONT_LP, 12'd0, 12'd0, 16'hFFFF, 8'sd127, -8'sd128);
    send_tick(12'd1, 8'sd127, 1'b1);
    send_tick(12'd4094, -8'sd128, 1'b0);
    send_tick(12'd7, 8'sd64, 1'b0);
    send_tick(12'd7, 8'sd64, 1'b0);
    send_tick(12'd7, 8'sd64, 1'b0);

    // Random phases, each with fresh settings and a load profile
    while (ticks_sent < TOTAL_TICKS) begin
      pick = $urandom_range(0, 9);
      mode = (pick == 0) ? MODE_OFF : (pick == 1) ? MODE_CONT :
             (pick == 2) ? MODE_CONT_LP : MODE_AUTO;
      pick = $urandom_range(0, 7);
      thr = (pick == 0) ? 12'd0 : (pick == 1) ? 12'hFFF : 12'($urandom_range(200, 2500));
      cal_thr = 12'($urandom_range(0, 1500));
      pick = $urandom_range(0, 7);
      cal_len = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(1, 400));
      hot_c = 8'($urandom_range(55, 90));
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        hot_c  = 8'sd127;
        cool_c = -8'sd128;
      end else if (pick == 1) begin
        cool_c = hot_c + 8'($urandom_range(1, 10));
      end else begin
        cool_c = hot_c - 8'($urandom_range(0, 10));
      end
      apply_settings(mode, thr, cal_thr, cal_len, hot_c, cool_c);

      load      = load_kind_t'($urandom_range(0, 3));
      len       = (load == LOAD_HEAVY) ? $urandom_range(220, 320) : $urandom_range(40, 160);
      cal_phase = ($urandom_range(0, 2) == 0);
      hot_phase = ($urandom_range(0, 4) == 0);
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);

      for (int i = 0; i < len && ticks_sent < TOTAL_TICKS; i++) begin
        if (ticks_sent >= TOTAL_TICKS - QUIET_TAIL) begin
          tx_gaps   = 1'b0;
          rx_stalls = 1'b0;
        end else if ($urandom_range(0, 399) == 0) begin
          wait_for_results();
        end
        send_tick(pick_current(load), pick_temp(hot_phase),
                  (cal_phase && i == 0) || ($urandom_range(0, 199) == 0));
      end
    end

    // Drain and verdict
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d ticks under %0d register settings, %0d results compared.",
             ticks_sent, settings_used, results_seen);
    $display("Calibration was started on %0d ticks across off, auto and continuous modes.",
             cal_starts);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/wtlds_pkg.sv
design/wtlds_cfg_regs.sv
design/wtlds_step.sv
design/wireless_tx_load_detect_sequencer_unit.sv
bench/load_detect_checker.sv
bench/tb_wireless_tx_load_detect_sequencer_unit.sv
